// ----- hw/rtl/dep_pkg.sv -----
`default_nettype none

package dep_pkg;

  localparam int DEP_BUFFER_BYTES = 512;
  localparam int DEP_QUEUE_DEPTH  = 2;

  localparam logic [7:0] DLE_CODE = 8'h10;
  localparam logic [7:0] ETX_CODE = 8'h03;

  localparam int POS_W = 9;
  localparam int LEN_W = 10;
  localparam int TS_W  = 64;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ABORT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_ETX   = 2'd1,
    OP_ABORT = 2'd2
  } op_t;

  // One classified input item, as handed from the front to the back.
  typedef struct packed {
    op_t                op;
    logic [7:0]         data;
    logic [POS_W-1:0]   pos;
    logic [LEN_W-1:0]   len;
    logic [TS_W-1:0]    stime;
  } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dep_front.sv -----
`default_nettype none

module dep_front
  import dep_pkg::*;
#(
  parameter int BUFFER_BYTES = DEP_BUFFER_BYTES
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_byte,
  input  wire logic [TS_W-1:0] timestamp,
  input  wire logic            q_full,
  output logic                 push,
  output cmd_t                 push_cmd
);

  localparam int CNT_W = $clog2(BUFFER_BYTES);
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(BUFFER_BYTES - 2);

  logic             in_packet, in_packet_next;
  logic             after_dle, after_dle_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [TS_W-1:0]  packet_start_time, packet_start_time_next;
  logic             accept;
  logic [CNT_W:0]   len_full;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign len_full = {1'b0, byte_count} + (CNT_W+1)'(2);

  always_comb begin
    in_packet_next         = in_packet;
    after_dle_next         = after_dle;
    byte_count_next        = byte_count;
    packet_start_time_next = packet_start_time;
    push                   = 1'b0;
    push_cmd.op            = OP_BYTE;
    push_cmd.data          = in_byte;
    push_cmd.pos           = POS_W'(byte_count);
    push_cmd.len           = '0;
    push_cmd.stime         = '0;
    if (accept && (in_packet || in_byte == DLE_CODE)) begin
      if (byte_count >= LIMIT) begin
        // drop the packet and report the overflow
        in_packet_next  = 1'b0;
        after_dle_next  = 1'b0;
        byte_count_next = '0;
        push            = 1'b1;
        push_cmd.op     = OP_ABORT;
        push_cmd.data   = '0;
        push_cmd.pos    = '0;
      end else if (!in_packet) begin
        in_packet_next         = 1'b1;
        after_dle_next         = 1'b0;
        packet_start_time_next = timestamp;
        byte_count_next        = CNT_W'(1);
        push                   = 1'b1;
        push_cmd.pos           = '0;
      end else if (in_byte == DLE_CODE) begin
        if (after_dle) begin
          after_dle_next  = 1'b0;
          byte_count_next = byte_count + CNT_W'(1);
          push            = 1'b1;
        end else begin
          after_dle_next = 1'b1;
        end
      end else if (in_byte == ETX_CODE && after_dle) begin
        push            = 1'b1;
        push_cmd.op     = OP_ETX;
        push_cmd.len    = LEN_W'(len_full);
        push_cmd.stime  = packet_start_time;
        byte_count_next = len_full[CNT_W-1:0];
        in_packet_next  = 1'b0;
        after_dle_next  = 1'b0;
      end else begin
        after_dle_next  = 1'b0;
        byte_count_next = byte_count + CNT_W'(1);
        push            = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet         <= 1'b0;
      after_dle         <= 1'b0;
      byte_count        <= '0;
      packet_start_time <= '0;
    end else begin
      in_packet         <= in_packet_next;
      after_dle         <= after_dle_next;
      byte_count        <= byte_count_next;
      packet_start_time <= packet_start_time_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dep_queue.sv -----
`default_nettype none

module dep_queue
  import dep_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      not_empty,
  output cmd_t      head
);

  localparam int PTR_W = (DEP_QUEUE_DEPTH > 1) ? $clog2(DEP_QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(DEP_QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEP_QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEP_QUEUE_DEPTH - 1);

  cmd_t             mem [DEP_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full      = (fill == FULL_CNT);
  assign not_empty = (fill != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dep_back.sv -----
`default_nettype none

module dep_back
  import dep_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         q_valid,
  input  cmd_t              head,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [7:0]        out_byte,
  output logic [POS_W-1:0]  position,
  output logic [1:0]        kind,
  output logic [LEN_W-1:0]  packet_length,
  output logic [TS_W-1:0]   start_time,
  output logic              last
);

  // second half of a DLE ETX pair
  logic  etx_phase;
  logic  take;
  kind_t kind_sel;

  assign out_valid = q_valid;
  assign take      = out_valid && out_ready;
  assign pop       = take && (head.op != OP_ETX || etx_phase);
  assign kind      = kind_sel;

  always_comb begin
    out_byte      = head.data;
    position      = head.pos;
    kind_sel      = KIND_BYTE;
    packet_length = '0;
    start_time    = '0;
    last          = 1'b1;
    case (head.op)
      OP_ETX: begin
        if (etx_phase) begin
          out_byte      = ETX_CODE;
          position      = head.pos + POS_W'(1);
          kind_sel      = KIND_DONE;
          packet_length = head.len;
          start_time    = head.stime;
        end else begin
          out_byte = DLE_CODE;
          last     = 1'b0;
        end
      end
      OP_ABORT: begin
        out_byte = '0;
        position = '0;
        kind_sel = KIND_ABORT;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      etx_phase <= 1'b0;
    end else if (take && head.op == OP_ETX) begin
      etx_phase <= !etx_phase;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dle_etx_packet_deframer_unit.sv -----
`default_nettype none
// DLE/ETX packet deframer.
// Input stream (s_axis_*): one received serial byte per item with its 64-bit
// arrival timestamp. Output stream (m_axis_*): unstuffed packet bytes,
// including the opening DLE and the closing DLE ETX, each with its position
// in the packet. m_axis_tuser carries the kind (0 packet byte, 1 final ETX
// of a complete packet, 2 packet dropped by overflow); m_axis_tlast marks
// the last result caused by one input item.
// A front stage classifies each item and updates the framing state in the
// cycle it is accepted, then pushes at most one command into a two-entry
// queue. The back stage expands a command into one result, or two for DLE ETX.
// An accepted item's command is registered in the queue, and results are
// driven from its head. Throughput: one item per cycle while the queue is not
// full; a DLE ETX gives two results, so the queue fill sets when s_axis_tready drops.
// Reset (rst, synchronous) empties the queue and leaves the block outside a
// packet with a zero byte count. When the receiver stalls, results wait in
// the queue and s_axis_tready falls once both entries are taken; no item is
// lost or repeated.

module dle_etx_packet_deframer_unit
  import dep_pkg::*;
#(
  parameter int BUFFER_BYTES = DEP_BUFFER_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // in_byte[7:0], timestamp[71:8]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_byte[7:0], position[16:8], packet_length[26:17], start_time[90:27], zero[95:91]
  output logic [95:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser,   // kind[1:0]
  output logic             m_axis_tlast    // last
);

  logic             push;
  cmd_t             push_cmd;
  logic             q_full;
  logic             q_valid;
  cmd_t             head;
  logic             pop;
  logic [7:0]       out_byte;
  logic [POS_W-1:0] position;
  logic [LEN_W-1:0] packet_length;
  logic [TS_W-1:0]  start_time;

  // classify input items and track framing state
  dep_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata[7:0]),
    .timestamp(s_axis_tdata[71:8]),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decouple front from back
  dep_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .not_empty(q_valid),
    .head     (head)
  );

  // expand commands into output items
  dep_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_byte     (out_byte),
    .position     (position),
    .kind         (m_axis_tuser),
    .packet_length(packet_length),
    .start_time   (start_time),
    .last         (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, start_time, packet_length, position, out_byte};

endmodule

`default_nettype wire
